@@ rtl/yc420_pkg.sv @@
// ----------------------------------------------------------------------------
// yc420_pkg
// Shared types, constants and helpers for the YCoCg-R 4:2:0 to BGRA8 converter.
// ----------------------------------------------------------------------------
package yc420_pkg;

  localparam int unsigned NumPix     = 4;
  localparam int unsigned WordW      = 16;
  localparam int unsigned PixelW     = 32;
  localparam int unsigned ChromaW    = 6;
  localparam int unsigned LumaW      = 10;
  localparam int unsigned ChanW      = 14;
  localparam int unsigned NumStages  = 5;

  typedef logic [LumaW-1:0]        luma_t;
  typedef logic signed [ChanW-1:0] chan_t;
  typedef logic [7:0]              byte_t;

  localparam chan_t ChromaCenter = chan_t'(1024);
  localparam chan_t ChanMax      = chan_t'(1023);
  localparam byte_t AlphaByte    = 8'hFF;

  function automatic byte_t clamp_to_byte(input chan_t v);
    byte_t res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > ChanMax) begin
      res = 8'hFF;
    end else begin
      res = v[LumaW-1:2];
    end
    return res;
  endfunction

endpackage

@@ rtl/ycocgr420_to_bgra8.sv @@
// ----------------------------------------------------------------------------
// ycocgr420_to_bgra8
// Converts one 2x2 YCoCg-R 4:2:0 group per unstalled cycle to four BGRA8 pixels.
// ----------------------------------------------------------------------------
//  channel | handshake                   | payload
//  --------+-----------------------------+-------------------------------------
//  in      | in_valid_i / in_stall_o     | word_{top,bottom}_{left,right}_i
//  out     | out_valid_o / out_stall_i   | pixel_{top,bottom}_{left,right}_o
//
//  Five register stages: unpack, t, g/b, r, clamp+pack.
//  One group per cycle sustained while out_stall_i is low; each stage holds one group.
//  Reset clears the stage valid bits only.
//  A stage advances when it is empty or the next one advances, so bubbles
//  collapse and, with every stage full, an out stall backs up to in_stall_o
//  in the same cycle.
// ----------------------------------------------------------------------------
module ycocgr420_to_bgra8
  import yc420_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [WordW-1:0]  word_top_left_i,
  input  logic [WordW-1:0]  word_top_right_i,
  input  logic [WordW-1:0]  word_bottom_left_i,
  input  logic [WordW-1:0]  word_bottom_right_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [PixelW-1:0] pixel_top_left_o,
  output logic [PixelW-1:0] pixel_top_right_o,
  output logic [PixelW-1:0] pixel_bottom_left_o,
  output logic [PixelW-1:0] pixel_bottom_right_o
);

  logic [NumStages-1:0] valid_q, valid_d, adv;

  logic [WordW-1:0] word_in [NumPix];
  chan_t            co_in, cg_in;

  // stage 1: luma and masked chroma per pixel
  luma_t y1_q  [NumPix];
  chan_t co1_q [NumPix], co1_d [NumPix];
  chan_t cg1_q [NumPix], cg1_d [NumPix];
  // stage 2
  chan_t co2_q [NumPix], cg2_q [NumPix], t2_q [NumPix], t2_d [NumPix];
  // stage 3
  chan_t co3_q [NumPix], g3_q [NumPix], b3_q [NumPix], g3_d [NumPix], b3_d [NumPix];
  // stage 4
  chan_t g4_q [NumPix], b4_q [NumPix], r4_q [NumPix], r4_d [NumPix];
  // stage 5
  logic [PixelW-1:0] pix_q [NumPix], pix_d [NumPix];

  assign word_in[0] = word_top_left_i;
  assign word_in[1] = word_top_right_i;
  assign word_in[2] = word_bottom_left_i;
  assign word_in[3] = word_bottom_right_i;

  assign co_in = chan_t'({word_top_left_i[ChromaW-1:0], word_top_right_i[ChromaW-1:0]})
                 - ChromaCenter;
  assign cg_in = chan_t'({word_bottom_left_i[ChromaW-1:0], word_bottom_right_i[ChromaW-1:0]})
                 - ChromaCenter;

  // advance chain, last stage first
  always_comb begin
    adv[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
    valid_d[0] = adv[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NumStages; k++) begin
      valid_d[k] = adv[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  assign in_stall_o = !adv[0];

  always_comb begin
    for (int p = 0; p < NumPix; p++) begin
      if (word_in[p][WordW-1:ChromaW] == '0) begin
        co1_d[p] = '0;
        cg1_d[p] = '0;
      end else begin
        co1_d[p] = co_in;
        cg1_d[p] = cg_in;
      end
      t2_d[p] = chan_t'({4'd0, y1_q[p]}) - (cg1_q[p] >>> 1);
      g3_d[p] = cg2_q[p] + t2_q[p];
      b3_d[p] = t2_q[p] - (co2_q[p] >>> 1);
      r4_d[p] = co3_q[p] + b3_q[p];
      pix_d[p] = {AlphaByte, clamp_to_byte(r4_q[p]), clamp_to_byte(g4_q[p]),
                  clamp_to_byte(b4_q[p])};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int p = 0; p < NumPix; p++) begin
      if (adv[0]) begin
        y1_q[p]  <= word_in[p][WordW-1:ChromaW];
        co1_q[p] <= co1_d[p];
        cg1_q[p] <= cg1_d[p];
      end
      if (adv[1]) begin
        co2_q[p] <= co1_q[p];
        cg2_q[p] <= cg1_q[p];
        t2_q[p]  <= t2_d[p];
      end
      if (adv[2]) begin
        co3_q[p] <= co2_q[p];
        g3_q[p]  <= g3_d[p];
        b3_q[p]  <= b3_d[p];
      end
      if (adv[3]) begin
        g4_q[p] <= g3_q[p];
        b4_q[p] <= b3_q[p];
        r4_q[p] <= r4_d[p];
      end
      if (adv[4]) begin
        pix_q[p] <= pix_d[p];
      end
    end
  end

  assign out_valid_o          = valid_q[NumStages-1];
  assign pixel_top_left_o     = pix_q[0];
  assign pixel_top_right_o    = pix_q[1];
  assign pixel_bottom_left_o  = pix_q[2];
  assign pixel_bottom_right_o = pix_q[3];

endmodule

@@ rtl/yc420_checker.sv @@
// ----------------------------------------------------------------------------
// yc420_checker
// Port-level checks for ycocgr420_to_bgra8, attached by bind.
// ----------------------------------------------------------------------------
module yc420_checker
  import yc420_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [PixelW-1:0] pixel_top_left_o,
  input logic [PixelW-1:0] pixel_top_right_o,
  input logic [PixelW-1:0] pixel_bottom_left_o,
  input logic [PixelW-1:0] pixel_bottom_right_o
);

  logic       in_xfer, out_xfer;
  logic [2:0] inflight_q, inflight_d;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  always_comb begin
    inflight_d = inflight_q;
    if (in_xfer && !out_xfer) begin
      inflight_d = inflight_q + 3'd1;
    end else if (!in_xfer && out_xfer) begin
      inflight_d = inflight_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inflight_q <= 3'(NumStages)) && (!out_valid_o || (inflight_q != 3'd0)))
    else $error("group count out of range");

  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pixel_top_left_o[31:24] == AlphaByte)
                 && (pixel_top_right_o[31:24] == AlphaByte)
                 && (pixel_bottom_left_o[31:24] == AlphaByte)
                 && (pixel_bottom_right_o[31:24] == AlphaByte))
    else $error("alpha byte not opaque");

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output stage");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_top_left_o)
      && $stable(pixel_bottom_right_o))
    else $error("stalled output changed");

endmodule

bind ycocgr420_to_bgra8 yc420_checker u_yc420_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_valid_i),
  .in_stall_o           (in_stall_o),
  .out_valid_o          (out_valid_o),
  .out_stall_i          (out_stall_i),
  .pixel_top_left_o     (pixel_top_left_o),
  .pixel_top_right_o    (pixel_top_right_o),
  .pixel_bottom_left_o  (pixel_bottom_left_o),
  .pixel_bottom_right_o (pixel_bottom_right_o)
);

@@ test/ycocgr420_to_bgra8_tb.sv @@
// ----------------------------------------------------------------------------
// ycocgr420_to_bgra8_tb
// Self-checking bench for the YCoCg-R 4:2:0 to BGRA8 group converter.
// A short table of directed groups covers black protection, chroma and luma
// extremes and the floor shift near the chroma center. Random groups follow.
// Expected pixels come from the table's fixed values for typed rows, else from
// a local model of the inverse transform, and are checked in order against every
// output transfer, with random stalls on both channels except in the last phase.
// ----------------------------------------------------------------------------
module ycocgr420_to_bgra8_tb;
  import yc420_pkg::*;

  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned RandGroups = 284;

  typedef logic [PixelW-1:0] pixel_t;
  typedef logic [NumPix-1:0][WordW-1:0] group_words_t;

  typedef struct packed {
    pixel_t tl;
    pixel_t tr;
    pixel_t bl;
    pixel_t br;
  } group_px_t;

  typedef struct packed {
    bit              typed;
    logic [WordW-1:0] tl;
    logic [WordW-1:0] tr;
    logic [WordW-1:0] bl;
    logic [WordW-1:0] br;
    pixel_t          etl;
    pixel_t          etr;
    pixel_t          ebl;
    pixel_t          ebr;
  } dir_row_t;

  localparam int unsigned NumDirRows = 20;

  localparam dir_row_t DirTable [NumDirRows] = '{
    '{1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      32'hFF000000, 32'hFF000000, 32'hFF000000, 32'hFF000000},
    '{1'b1, 16'h003F, 16'h003F, 16'h003F, 16'h003F,
      32'hFF000000, 32'hFF000000, 32'hFF000000, 32'hFF000000},
    '{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      32'hFFFFFF00, 32'hFFFFFF00, 32'hFFFFFF00, 32'hFFFFFF00},
    '{1'b1, 16'hFFD0, 16'hFFC0, 16'hFFD0, 16'hFFC0,
      32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
    '{1'b1, 16'h0110, 16'h0100, 16'h0110, 16'h0100,
      32'hFF010101, 32'hFF010101, 32'hFF010101, 32'hFF010101},
    '{1'b1, 16'hFFC0, 16'hFFC0, 16'hFFC0, 16'hFFC0,
      32'hFFFF7FFF, 32'hFFFF7FFF, 32'hFFFF7FFF, 32'hFFFF7FFF},
    '{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFC0, 16'hFFC0, '0, '0, '0, '0},
    '{1'b0, 16'hFFC0, 16'hFFC0, 16'hFFFF, 16'hFFFF, '0, '0, '0, '0},
    '{1'b0, 16'h007F, 16'h007F, 16'h0040, 16'h0040, '0, '0, '0, '0},
    '{1'b0, 16'h0040, 16'h0040, 16'h007F, 16'h007F, '0, '0, '0, '0},
    '{1'b0, 16'h003F, 16'hFFFF, 16'h8000, 16'h0000, '0, '0, '0, '0},
    '{1'b0, 16'h8010, 16'h8000, 16'h800F, 16'h803F, '0, '0, '0, '0},
    '{1'b0, 16'h800F, 16'h803F, 16'h8010, 16'h8000, '0, '0, '0, '0},
    '{1'b0, 16'h8010, 16'h8001, 16'h8010, 16'h8001, '0, '0, '0, '0},
    '{1'b0, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, '0, '0, '0, '0},
    '{1'b0, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, '0, '0, '0, '0},
    '{1'b0, 16'h1230, 16'h4567, 16'h89AB, 16'hCDEF, '0, '0, '0, '0},
    '{1'b0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, '0, '0, '0, '0},
    '{1'b0, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, '0, '0, '0, '0},
    '{1'b0, 16'h7FD0, 16'h4020, 16'hC00C, 16'h0031, '0, '0, '0, '0}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [WordW-1:0]   word_top_left_i;
  logic [WordW-1:0]   word_top_right_i;
  logic [WordW-1:0]   word_bottom_left_i;
  logic [WordW-1:0]   word_bottom_right_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [PixelW-1:0]  pixel_top_left_o;
  logic [PixelW-1:0]  pixel_top_right_o;
  logic [PixelW-1:0]  pixel_bottom_left_o;
  logic [PixelW-1:0]  pixel_bottom_right_o;

  group_px_t   pending_px [$];
  group_px_t   cur_exp;
  group_px_t   got_px;
  group_px_t   want_px;
  bit          cur_typed;
  logic        in_fire_q = 1'b0;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned group_cnt;
  int unsigned result_cnt;
  int unsigned typed_cnt;
  int unsigned err_cnt;
  int unsigned idle_cycles;

  ycocgr420_to_bgra8 u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .word_top_left_i      (word_top_left_i),
    .word_top_right_i     (word_top_right_i),
    .word_bottom_left_i   (word_bottom_left_i),
    .word_bottom_right_i  (word_bottom_right_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .pixel_top_left_o     (pixel_top_left_o),
    .pixel_top_right_o    (pixel_top_right_o),
    .pixel_bottom_left_o  (pixel_bottom_left_o),
    .pixel_bottom_right_o (pixel_bottom_right_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic byte_t chan_byte(input chan_t v);
    if (v < 0) begin
      return 8'h00;
    end
    if (v > chan_t'(1023)) begin
      return 8'hFF;
    end
    return v[9:2];
  endfunction

  function automatic pixel_t ycocg_pixel(input logic [WordW-1:0] word,
                                         input chan_t co, input chan_t cg);
    chan_t y;
    chan_t t;
    chan_t g;
    chan_t b;
    chan_t r;
    y = chan_t'(word[WordW-1:ChromaW]);
    // keep black pixels black
    if (y == 0) begin
      co = '0;
      cg = '0;
    end
    t = y - (cg >>> 1);
    g = cg + t;
    b = t - (co >>> 1);
    r = co + b;
    return {AlphaByte, chan_byte(r), chan_byte(g), chan_byte(b)};
  endfunction

  function automatic group_px_t predict_group(input group_words_t w);
    chan_t     co;
    chan_t     cg;
    group_px_t res;
    co = chan_t'({w[0][ChromaW-1:0], w[1][ChromaW-1:0]}) - chan_t'(1024);
    cg = chan_t'({w[2][ChromaW-1:0], w[3][ChromaW-1:0]}) - chan_t'(1024);
    res.tl = ycocg_pixel(w[0], co, cg);
    res.tr = ycocg_pixel(w[1], co, cg);
    res.bl = ycocg_pixel(w[2], co, cg);
    res.br = ycocg_pixel(w[3], co, cg);
    return res;
  endfunction

  function automatic group_words_t random_group();
    logic [LumaW-1:0]     y [NumPix];
    logic [2*ChromaW-1:0] co_raw;
    logic [2*ChromaW-1:0] cg_raw;
    int unsigned          mode;
    group_words_t         w;
    mode = $urandom_range(9);
    for (int i = 0; i < NumPix; i++) begin
      y[i] = LumaW'($urandom);
    end
    co_raw = 12'($urandom);
    cg_raw = 12'($urandom);
    case (mode)
      4, 5: begin
        co_raw = 12'(992 + $urandom_range(64));
        cg_raw = 12'(992 + $urandom_range(64));
      end
      6: begin
        co_raw = $urandom_range(1) ? 12'hFFF : 12'h000;
        cg_raw = $urandom_range(1) ? 12'hFFF : 12'h000;
      end
      7: begin
        for (int i = 0; i < NumPix; i++) begin
          if ($urandom_range(1) == 0) y[i] = '0;
        end
      end
      8: begin
        for (int i = 0; i < NumPix; i++) begin
          case ($urandom_range(3))
            0: y[i] = 10'd0;
            1: y[i] = 10'd1;
            2: y[i] = 10'd1022;
            default: y[i] = 10'd1023;
          endcase
        end
      end
      9: begin
        for (int i = 0; i < NumPix; i++) begin
          y[i] = 10'($urandom_range(15));
        end
      end
      default: ;
    endcase
    w[0] = {y[0], co_raw[11:6]};
    w[1] = {y[1], co_raw[5:0]};
    w[2] = {y[2], cg_raw[11:6]};
    w[3] = {y[3], cg_raw[5:0]};
    if (mode < 4) begin
      for (int i = 0; i < NumPix; i++) begin
        w[i] = WordW'($urandom);
      end
    end
    return w;
  endfunction

  // drive one group and hold it until the transfer
  task automatic send_group(input group_words_t w, input bit typed,
                            input group_px_t exp_px);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i          = 1'b1;
    word_top_left_i     = w[0];
    word_top_right_i    = w[1];
    word_bottom_left_i  = w[2];
    word_bottom_right_i = w[3];
    cur_typed           = typed;
    cur_exp             = exp_px;
    @(negedge clk_i);
    while (!in_fire_q) @(negedge clk_i);
  endtask

  task automatic check_px(input string pos, input pixel_t want, input pixel_t got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s pixel mismatch, expected %h actual %h", $time, pos, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    in_fire_q <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        group_cnt++;
        if (cur_typed) begin
          typed_cnt++;
          pending_px.push_back(cur_exp);
        end else begin
          pending_px.push_back(predict_group({word_bottom_right_i, word_bottom_left_i,
                                              word_top_right_i, word_top_left_i}));
        end
      end
      if (out_valid_o && !out_stall_i) begin
        result_cnt++;
        got_px = {pixel_top_left_o, pixel_top_right_o,
                  pixel_bottom_left_o, pixel_bottom_right_o};
        if (pending_px.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected transfer, expected none actual %h", $time, got_px);
        end else begin
          want_px = pending_px.pop_front();
          check_px("top-left", want_px.tl, got_px.tl);
          check_px("top-right", want_px.tr, got_px.tr);
          check_px("bottom-left", want_px.bl, got_px.bl);
          check_px("bottom-right", want_px.br, got_px.br);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      out_stall_i = ($urandom_range(99) < rx_stall_pct);
    end
  end

  initial begin
    dir_row_t row;
    rst_ni              = 1'b0;
    in_valid_i          = 1'b0;
    out_stall_i         = 1'b0;
    word_top_left_i     = '0;
    word_top_right_i    = '0;
    word_bottom_left_i  = '0;
    word_bottom_right_i = '0;
    cur_typed           = 1'b0;
    cur_exp             = '0;
    tx_idle_pct         = 10;
    rx_stall_pct        = 67;
    group_cnt           = 0;
    result_cnt          = 0;
    typed_cnt           = 0;
    err_cnt             = 0;
    idle_cycles         = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumDirRows; i++) begin
      row = DirTable[i];
      send_group({row.br, row.bl, row.tr, row.tl}, row.typed,
                 '{row.etl, row.etr, row.ebl, row.ebr});
    end

    // hold off until the pipeline drains
    in_valid_i = 1'b0;
    while (pending_px.size() != 0) @(negedge clk_i);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 10; rx_stall_pct = 67; end
        1: begin tx_idle_pct = 67; rx_stall_pct = 10; end
        default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
      endcase
      for (int n = 0; n < RandGroups; n++) begin
        send_group(random_group(), 1'b0, '0);
      end
    end

    in_valid_i = 1'b0;
    while (pending_px.size() != 0) @(negedge clk_i);
    repeat (4 * NumStages) @(negedge clk_i);

    $display("%0d pixel groups converted (%0d with fixed expectations), %0d results checked",
             group_cnt, typed_cnt, result_cnt);
    $display("stall mixes: light/heavy, heavy/light, none; %0d mismatches", err_cnt);
    if (err_cnt == 0 && pending_px.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/yc420_pkg.sv
rtl/ycocgr420_to_bgra8.sv
rtl/yc420_checker.sv
test/ycocgr420_to_bgra8_tb.sv
